[hdl/pcg_pkg.sv]
// ----------------------------------------------------------------------------
// PML coefficient generator package
// Shared widths, register defaults, codes and the divider control type.
// ----------------------------------------------------------------------------
package pcg_pkg;

  localparam int MAX_PML_DEPTH_DEF = 64;
  localparam int COEF_WIDTH_DEF    = 32;

  localparam int DEPTH_W = 7;
  localparam int CDT_W   = 31;
  localparam int MU_W    = 32;
  localparam int CFG_W   = 32;
  localparam int CDT_FRAC = 30;

  localparam logic [DEPTH_W-1:0] GRADE_CELLS_RST = 7'd16;
  localparam logic [CDT_W-1:0]   C_DT_RST        = 31'd536870912;
  localparam logic [MU_W-1:0]    MU_RST          = 32'd268435456;

  localparam logic [1:0] CFG_GRADE_CELLS = 2'd0;
  localparam logic [1:0] CFG_C_DT        = 2'd1;
  localparam logic [1:0] CFG_MU_X        = 2'd2;
  localparam logic [1:0] CFG_MU_Y        = 2'd3;

  typedef enum logic [1:0] {
    KIND_HX = 2'd0,
    KIND_HY = 2'd1,
    KIND_DZ = 2'd2
  } kind_t;

  typedef struct packed {
    logic neg;
    logic kill;
    logic tag;
  } div_ctl_t;

endpackage

[hdl/pcg_divider.sv]
// ----------------------------------------------------------------------------
// PML coefficient divider
// Pipelined restoring divider, one quotient bit per stage, with rounding to
// nearest, saturation to the signed range and optional negation.
// ----------------------------------------------------------------------------
module pcg_divider #(
  parameter int NUM_W      = 82,
  parameter int DEN_W      = 57,
  parameter int COEF_WIDTH = pcg_pkg::COEF_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [NUM_W-1:0]             num,
  input  logic [DEN_W-1:0]             den,
  input  pcg_pkg::div_ctl_t            ctl,
  output logic signed [COEF_WIDTH-1:0] coef,
  output logic                         tag_out
);

  localparam int X_W = (NUM_W + 1 > DEN_W + COEF_WIDTH + 1) ? NUM_W + 1
                                                            : DEN_W + COEF_WIDTH + 1;
  localparam int QW  = COEF_WIDTH + 1;
  localparam int STG = COEF_WIDTH + 2;

  logic [X_W-1:0]     r      [STG];
  logic [DEN_W-1:0]   d      [STG];
  logic [QW-1:0]      qb     [STG];
  logic               sat    [STG];
  pcg_pkg::div_ctl_t  cs     [STG];

  logic [X_W-1:0]     r_next  [1:STG-1];
  logic [QW-1:0]      qb_next [1:STG-1];
  logic [X_W-1:0]     trial   [1:STG-1];

  logic [QW:0]        rounded;
  logic [QW-1:0]      mag;
  logic [QW-1:0]      limit;
  logic [QW-1:0]      mag_sat;
  logic [COEF_WIDTH-1:0] coef_next;

  always_comb begin
    for (int j = 1; j < STG; j++) begin
      trial[j] = X_W'(d[j-1]) << (STG - 1 - j);
      if (r[j-1] >= trial[j]) begin
        r_next[j]  = r[j-1] - trial[j];
        qb_next[j] = qb[j-1] | (QW'(1) << (STG - 1 - j));
      end else begin
        r_next[j]  = r[j-1];
        qb_next[j] = qb[j-1];
      end
    end
  end

  always_comb begin
    rounded = {1'b0, qb[STG-1]} + (QW+1)'(1);
    mag     = rounded[QW:1];
    limit   = cs[STG-1].neg ? (QW'(1) << (COEF_WIDTH - 1))
                            : (QW'(1) << (COEF_WIDTH - 1)) - QW'(1);
    mag_sat = (sat[STG-1] || (mag > limit)) ? limit : mag;
    if (cs[STG-1].kill) begin
      coef_next = '0;
    end else if (cs[STG-1].neg) begin
      coef_next = COEF_WIDTH'(QW'(0) - mag_sat);
    end else begin
      coef_next = COEF_WIDTH'(mag_sat);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r[0]   <= X_W'(num) << 1;
      d[0]   <= den;
      qb[0]  <= '0;
      sat[0] <= (den == '0) || (X_W'(num) >= (X_W'(den) << COEF_WIDTH));
      cs[0]  <= ctl;
      for (int j = 1; j < STG; j++) begin
        r[j]   <= r_next[j];
        d[j]   <= d[j-1];
        qb[j]  <= qb_next[j];
        sat[j] <= sat[j-1];
        cs[j]  <= cs[j-1];
      end
      coef    <= coef_next;
      tag_out <= cs[STG-1].tag;
    end
  end

endmodule

[hdl/pml_coefficient_generator.sv]
// ----------------------------------------------------------------------------
// PML coefficient generator
// Computes the four Q2.30 update coefficients of one PML cell for Hx, Hy or
// Dz from the cubic grades of its x and y depths.
// ----------------------------------------------------------------------------
//  Channel   Signals                                        Handshake
//  input     req_type x_depth y_depth                       in_valid / in_stall
//  output    coef_one coef_two coef_three coef_four         out_valid / out_stall
//  config    cfg_index cfg_data                             cfg_valid / cfg_ready
//
// One item enters per cycle while the output is not stalled.
// The three restoring dividers compute one quotient bit a stage.
// Reset loads the register defaults and clears all valid bits.
// A stalled result holds the whole pipeline, and in_stall follows it.
// ----------------------------------------------------------------------------
module pml_coefficient_generator #(
  parameter int MAX_PML_DEPTH = pcg_pkg::MAX_PML_DEPTH_DEF,
  parameter int COEF_WIDTH    = pcg_pkg::COEF_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    req_type,
  input  logic [pcg_pkg::DEPTH_W-1:0]   x_depth,
  input  logic [pcg_pkg::DEPTH_W-1:0]   y_depth,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COEF_WIDTH-1:0]  coef_one,
  output logic signed [COEF_WIDTH-1:0]  coef_two,
  output logic signed [COEF_WIDTH-1:0]  coef_three,
  output logic signed [COEF_WIDTH-1:0]  coef_four,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [pcg_pkg::CFG_W-1:0]     cfg_data
);

  localparam int FRAC  = COEF_WIDTH - 2;
  localparam int NSH   = (FRAC >= pcg_pkg::CDT_FRAC) ? FRAC - pcg_pkg::CDT_FRAC : 0;
  localparam int DSH   = (FRAC < pcg_pkg::CDT_FRAC) ? pcg_pkg::CDT_FRAC - FRAC : 0;
  localparam int NUM_W = (52 + FRAC >= 77) ? 52 + FRAC : 77;
  localparam int DEN_W = (48 + DSH > 57) ? 48 + DSH : 57;
  localparam int LAT   = 7 + COEF_WIDTH + 3;
  localparam logic [6:0] P_MAX = (MAX_PML_DEPTH >= 127) ? 7'd127 : 7'(MAX_PML_DEPTH);

  logic [6:0]  grade_cells;
  logic [30:0] c_dt;
  logic [31:0] mu_x;
  logic [31:0] mu_y;

  logic           en;
  logic [LAT-1:0] vld;

  logic [6:0]  p_eff, kx_in, ky_in;

  logic [1:0]  s0_kind, s1_kind, s2_kind, s3_kind, s4_kind, s5_kind;
  logic [6:0]  s0_p, s0_kx, s0_ky, s1_p, s1_kx, s1_ky;
  logic [13:0] s1_p2, s1_kx2, s1_ky2;
  logic [20:0] s2_p3, s2_x, s2_y;

  logic [22:0] q_c;
  logic [20:0] s_c, t_c;
  logic [31:0] m_c;

  logic [22:0] s3_q, s3_qms;
  logic [20:0] s3_x, s3_y;
  logic [23:0] s3_qs, s3_qx, s3_qy;
  logic [21:0] s3_xsum;
  logic [31:0] s3_m;
  logic [51:0] s3_cdtp3, s3_cdtt;

  logic [22:0] s4_qms;
  logic [23:0] s4_qs;
  logic [51:0] s4_cdtp3, s4_cdtt;
  logic [55:0] s4_mqs;
  logic [45:0] s4_qq;
  logic [44:0] s4_qxs;
  logic [41:0] s4_xy;
  logic [47:0] s4_dprod;

  logic [22:0] s5_qms;
  logic [23:0] s5_qs;
  logic [51:0] s5_cdtp3, s5_cdtt;
  logic [55:0] s5_mqs;
  logic [45:0] s5_n1;
  logic [53:0] s5_cq_lo, s5_cq_hi;
  logic [41:0] s5_xy;
  logic [47:0] s5_dprod;

  logic [76:0] n2_c;
  logic [NUM_W-1:0] a_num_c, b_num_c, c_num_c, a_num, b_num, c_num;
  logic [DEN_W-1:0] a_den_c, b_den_c, c_den_c, a_den, b_den, c_den;
  pcg_pkg::div_ctl_t a_ctl_c, b_ctl_c, c_ctl_c, a_ctl, b_ctl, c_ctl;

  logic signed [COEF_WIDTH-1:0] a_coef, b_coef, c_coef;
  logic c_tag;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      grade_cells <= pcg_pkg::GRADE_CELLS_RST;
      c_dt        <= pcg_pkg::C_DT_RST;
      mu_x        <= pcg_pkg::MU_RST;
      mu_y        <= pcg_pkg::MU_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        pcg_pkg::CFG_GRADE_CELLS: grade_cells <= cfg_data[6:0];
        pcg_pkg::CFG_C_DT:        c_dt        <= cfg_data[30:0];
        pcg_pkg::CFG_MU_X:        mu_x        <= cfg_data;
        pcg_pkg::CFG_MU_Y:        mu_y        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_comb begin
    if (grade_cells == 7'd0) begin
      p_eff = 7'd1;
    end else if (grade_cells > P_MAX) begin
      p_eff = P_MAX;
    end else begin
      p_eff = grade_cells;
    end
    kx_in = (x_depth > p_eff) ? p_eff : x_depth;
    ky_in = (y_depth > p_eff) ? p_eff : y_depth;
  end

  always_comb begin
    q_c = {s2_p3, 2'b00};
    case (s2_kind)
      pcg_pkg::KIND_HY: begin
        s_c = s2_x;
        t_c = s2_y;
        m_c = mu_y;
      end
      default: begin
        s_c = s2_y;
        t_c = s2_x;
        m_c = mu_x;
      end
    endcase
  end

  always_comb begin
    n2_c = (77'(s5_cq_hi) << 23) + 77'(s5_cq_lo);
    case (s5_kind)
      pcg_pkg::KIND_HX, pcg_pkg::KIND_HY: begin
        a_num_c = NUM_W'(s5_qms) << FRAC;
        a_den_c = DEN_W'(s5_qs);
        a_ctl_c = '{neg: 1'b0, kill: 1'b0, tag: 1'b0};
        b_num_c = NUM_W'(s5_cdtp3) << FRAC;
        b_den_c = DEN_W'(s5_mqs);
        b_ctl_c = '{neg: 1'b1, kill: 1'b0, tag: 1'b0};
        c_num_c = NUM_W'(s5_cdtt) << FRAC;
        c_den_c = DEN_W'(s5_mqs) << 1;
        c_ctl_c = '{neg: 1'b1, kill: 1'b0, tag: 1'b0};
      end
      pcg_pkg::KIND_DZ: begin
        a_num_c = NUM_W'(s5_n1) << FRAC;
        a_den_c = DEN_W'(s5_dprod);
        a_ctl_c = '{neg: 1'b0, kill: 1'b0, tag: 1'b1};
        b_num_c = NUM_W'(n2_c) << NSH;
        b_den_c = DEN_W'(s5_dprod) << DSH;
        b_ctl_c = '{neg: 1'b0, kill: 1'b0, tag: 1'b1};
        c_num_c = NUM_W'(s5_xy) << (FRAC + 2);
        c_den_c = DEN_W'(s5_dprod);
        c_ctl_c = '{neg: 1'b1, kill: 1'b0, tag: 1'b1};
      end
      default: begin
        a_num_c = '0;
        a_den_c = DEN_W'(1);
        a_ctl_c = '{neg: 1'b0, kill: 1'b1, tag: 1'b0};
        b_num_c = '0;
        b_den_c = DEN_W'(1);
        b_ctl_c = '{neg: 1'b0, kill: 1'b1, tag: 1'b0};
        c_num_c = '0;
        c_den_c = DEN_W'(1);
        c_ctl_c = '{neg: 1'b0, kill: 1'b1, tag: 1'b0};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_kind <= req_type;
      s0_p    <= p_eff;
      s0_kx   <= kx_in;
      s0_ky   <= ky_in;

      s1_kind <= s0_kind;
      s1_p    <= s0_p;
      s1_kx   <= s0_kx;
      s1_ky   <= s0_ky;
      s1_p2   <= 14'(s0_p) * 14'(s0_p);
      s1_kx2  <= 14'(s0_kx) * 14'(s0_kx);
      s1_ky2  <= 14'(s0_ky) * 14'(s0_ky);

      s2_kind <= s1_kind;
      s2_p3   <= 21'(s1_p2) * 21'(s1_p);
      s2_x    <= 21'(s1_kx2) * 21'(s1_kx);
      s2_y    <= 21'(s1_ky2) * 21'(s1_ky);

      s3_kind  <= s2_kind;
      s3_q     <= q_c;
      s3_x     <= s2_x;
      s3_y     <= s2_y;
      s3_qs    <= 24'(q_c) + 24'(s_c);
      s3_qms   <= q_c - 23'(s_c);
      s3_qx    <= 24'(q_c) + 24'(s2_x);
      s3_qy    <= 24'(q_c) + 24'(s2_y);
      s3_xsum  <= 22'(s2_x) + 22'(s2_y);
      s3_m     <= m_c;
      s3_cdtp3 <= 52'(c_dt) * 52'(s2_p3);
      s3_cdtt  <= 52'(c_dt) * 52'(t_c);

      s4_kind  <= s3_kind;
      s4_qms   <= s3_qms;
      s4_qs    <= s3_qs;
      s4_cdtp3 <= s3_cdtp3;
      s4_cdtt  <= s3_cdtt;
      s4_mqs   <= 56'(s3_m) * 56'(s3_qs);
      s4_qq    <= 46'(s3_q) * 46'(s3_q);
      s4_qxs   <= 45'(s3_q) * 45'(s3_xsum);
      s4_xy    <= 42'(s3_x) * 42'(s3_y);
      s4_dprod <= 48'(s3_qx) * 48'(s3_qy);

      s5_kind  <= s4_kind;
      s5_qms   <= s4_qms;
      s5_qs    <= s4_qs;
      s5_cdtp3 <= s4_cdtp3;
      s5_cdtt  <= s4_cdtt;
      s5_mqs   <= s4_mqs;
      s5_xy    <= s4_xy;
      s5_dprod <= s4_dprod;
      s5_n1    <= s4_qq - 46'(s4_qxs) - 46'(s4_xy);
      s5_cq_lo <= 54'(s4_qq[22:0]) * 54'(c_dt);
      s5_cq_hi <= 54'(s4_qq[45:23]) * 54'(c_dt);

      a_num <= a_num_c;
      a_den <= a_den_c;
      a_ctl <= a_ctl_c;
      b_num <= b_num_c;
      b_den <= b_den_c;
      b_ctl <= b_ctl_c;
      c_num <= c_num_c;
      c_den <= c_den_c;
      c_ctl <= c_ctl_c;
    end
  end

  pcg_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W), .COEF_WIDTH(COEF_WIDTH)) u_div_a (
    .clk(clk), .en(en), .num(a_num), .den(a_den), .ctl(a_ctl),
    .coef(a_coef), .tag_out()
  );

  pcg_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W), .COEF_WIDTH(COEF_WIDTH)) u_div_b (
    .clk(clk), .en(en), .num(b_num), .den(b_den), .ctl(b_ctl),
    .coef(b_coef), .tag_out()
  );

  pcg_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W), .COEF_WIDTH(COEF_WIDTH)) u_div_c (
    .clk(clk), .en(en), .num(c_num), .den(c_den), .ctl(c_ctl),
    .coef(c_coef), .tag_out(c_tag)
  );

  assign coef_one   = a_coef;
  assign coef_two   = b_coef;
  assign coef_three = c_tag ? '0 : c_coef;
  assign coef_four  = c_tag ? c_coef : '0;

endmodule

[hdl/pcg_checker.sv]
// ----------------------------------------------------------------------------
// PML coefficient generator checker
// Port-level checks on the output channel and the stall path.
// ----------------------------------------------------------------------------
module pcg_checker #(
  parameter int COEF_WIDTH = pcg_pkg::COEF_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [COEF_WIDTH-1:0]  coef_one,
  input logic signed [COEF_WIDTH-1:0]  coef_two,
  input logic signed [COEF_WIDTH-1:0]  coef_three,
  input logic signed [COEF_WIDTH-1:0]  coef_four
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output valid after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(coef_one) && $stable(coef_two)
      && $stable(coef_three) && $stable(coef_four))
    else $error("Stalled item changed.");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("Input stalled with an empty output.");

  a_three_four_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (coef_three == '0) || (coef_four == '0))
    else $error("Both integrated coefficients nonzero.");

  a_four_nonpositive: assert property (@(posedge clk) disable iff (rst)
    out_valid && (coef_four != '0) |-> coef_four[COEF_WIDTH-1])
    else $error("Integrated field coefficient positive.");

endmodule

bind pml_coefficient_generator pcg_checker #(
  .COEF_WIDTH(COEF_WIDTH)
) u_pcg_checker (.*);
